// File: rtl/ecal_pkg.sv
// shared types, constants and helper functions for the epoch to utc calendar block
// used by ecal_divider, the top level and the checker; depends on nothing
package ecal_pkg;

    localparam int unsigned LAST_YEAR_DEF = 2100;
    localparam int unsigned YEAR_BASE     = 1900;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_PER_WEEK = 7;

    localparam logic [7:0] FIRST_YY   = 8'd70;   // 1970
    localparam logic [7:0] YY_2100    = 8'd200;  // century year that is not leap
    localparam logic [2:0] EPOCH_WDAY = 3'd4;    // thursday
    localparam logic [8:0] DAYS_YEAR  = 9'd365;
    localparam logic [8:0] DAYS_LEAP  = 9'd366;
    localparam logic [4:0] FEB_DAYS   = 5'd28;
    localparam logic [3:0] LAST_MON   = 4'd11;

    // reciprocals of the odd parts of the divisors, rounded up
    localparam logic [25:0] RECIP_DAY  = 26'd50903317;  // 2^35 / 675
    localparam logic [25:0] RECIP_WEEK = 26'd74;        // 2^9 / 7
    localparam logic [25:0] RECIP_HOUR = 26'd9321;      // 2^21 / 225
    localparam logic [25:0] RECIP_MIN  = 26'd1093;      // 2^14 / 15

    localparam int unsigned DIV_W  = 32;
    localparam int unsigned QUO_W  = 16;
    localparam int unsigned PC_W   = 4;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [3:0] {
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_SAVE_DAYS,
        UOP_YEAR,
        UOP_MON_START,
        UOP_MONTH,
        UOP_SAVE_WEEK,
        UOP_SAVE_HOUR,
        UOP_SAVE_MIN,
        UOP_DONE
    } t_uop;

    typedef enum logic [1:0] {
        DSEL_DAY,
        DSEL_WEEK,
        DSEL_HOUR,
        DSEL_MIN
    } t_dsel;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_DIV_MORE,
        COND_YEAR_MORE,
        COND_MONTH_MORE
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_dsel dsel;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic             init;
        logic             step;
        t_dsel            sel;
        logic [DIV_W-1:0] dividend;
    } t_div_ctl;

    typedef struct packed {
        logic             more;
        logic [QUO_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } t_div_stat;

    localparam t_pc PC_DONE = 4'd14;

    // microprogram: one control word per step
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            4'd0:  w = '{op: UOP_DIV_STEP,  dsel: DSEL_DAY,  cond: COND_DIV_MORE,   target: 4'd0};
            4'd1:  w = '{op: UOP_SAVE_DAYS, dsel: DSEL_DAY,  cond: COND_NONE,       target: 4'd0};
            4'd2:  w = '{op: UOP_YEAR,      dsel: DSEL_DAY,  cond: COND_YEAR_MORE,  target: 4'd2};
            4'd3:  w = '{op: UOP_MON_START, dsel: DSEL_DAY,  cond: COND_NONE,       target: 4'd0};
            4'd4:  w = '{op: UOP_MONTH,     dsel: DSEL_DAY,  cond: COND_MONTH_MORE, target: 4'd4};
            4'd5:  w = '{op: UOP_DIV_INIT,  dsel: DSEL_WEEK, cond: COND_NONE,       target: 4'd0};
            4'd6:  w = '{op: UOP_DIV_STEP,  dsel: DSEL_WEEK, cond: COND_DIV_MORE,   target: 4'd6};
            4'd7:  w = '{op: UOP_SAVE_WEEK, dsel: DSEL_WEEK, cond: COND_NONE,       target: 4'd0};
            4'd8:  w = '{op: UOP_DIV_INIT,  dsel: DSEL_HOUR, cond: COND_NONE,       target: 4'd0};
            4'd9:  w = '{op: UOP_DIV_STEP,  dsel: DSEL_HOUR, cond: COND_DIV_MORE,   target: 4'd9};
            4'd10: w = '{op: UOP_SAVE_HOUR, dsel: DSEL_HOUR, cond: COND_NONE,       target: 4'd0};
            4'd11: w = '{op: UOP_DIV_INIT,  dsel: DSEL_MIN,  cond: COND_NONE,       target: 4'd0};
            4'd12: w = '{op: UOP_DIV_STEP,  dsel: DSEL_MIN,  cond: COND_DIV_MORE,   target: 4'd12};
            4'd13: w = '{op: UOP_SAVE_MIN,  dsel: DSEL_MIN,  cond: COND_NONE,       target: 4'd0};
            default: w = '{op: UOP_DONE,    dsel: DSEL_DAY,  cond: COND_NONE,       target: 4'd0};
        endcase
        return w;
    endfunction

    // year given as offset from 1900, valid for 1970 to 2106
    function automatic logic leap_yy(input logic [7:0] yy);
        return (yy[1:0] == 2'b00) && (yy != YY_2100);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] n;
        case (mon)
            4'd1:                      n = leap ? 5'd29 : FEB_DAYS;
            4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    // weekday advance modulo 7, step at most 3
    function automatic logic [2:0] wd_add(input logic [2:0] wd, input logic [1:0] inc);
        logic [3:0] s;
        s = {1'b0, wd} + {2'b00, inc};
        return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
    endfunction

endpackage

// File: rtl/ecal_divider.sv
// constant divider: quotient by reciprocal multiplication, remainder by multiplying back,
// two steps per division; depends on ecal_pkg for the control and status structs
module ecal_divider (
    input  logic                i_clk,
    input  ecal_pkg::t_div_ctl  i_ctl,
    output ecal_pkg::t_div_stat o_stat
);

    logic [ecal_pkg::DIV_W-1:0] r_num, n_num;
    ecal_pkg::t_dsel            r_sel, n_sel;
    logic [ecal_pkg::QUO_W-1:0] r_quo, n_quo;
    logic                       r_phase, n_phase;
    logic [24:0]                pre;
    logic [25:0]                recip;
    logic [16:0]                dsr;
    logic [50:0]                prod;
    logic [ecal_pkg::QUO_W-1:0] quo_est;
    logic [32:0]                back;

    // power of two of each divisor is shifted off first, the odd part goes by reciprocal
    always_comb begin
        unique case (r_sel)
            ecal_pkg::DSEL_WEEK: begin
                pre   = 25'(r_num[5:0]);
                recip = ecal_pkg::RECIP_WEEK;
                dsr   = 17'(ecal_pkg::DAYS_PER_WEEK);
            end
            ecal_pkg::DSEL_HOUR: begin
                pre   = 25'(r_num[16:4]);
                recip = ecal_pkg::RECIP_HOUR;
                dsr   = 17'(ecal_pkg::SECS_PER_HOUR);
            end
            ecal_pkg::DSEL_MIN: begin
                pre   = 25'(r_num[11:2]);
                recip = ecal_pkg::RECIP_MIN;
                dsr   = 17'(ecal_pkg::SECS_PER_MIN);
            end
            default: begin
                pre   = r_num[31:7];
                recip = ecal_pkg::RECIP_DAY;
                dsr   = 17'(ecal_pkg::SECS_PER_DAY);
            end
        endcase
        prod = 51'(pre) * 51'(recip);
        unique case (r_sel)
            ecal_pkg::DSEL_WEEK: quo_est = prod[24:9];
            ecal_pkg::DSEL_HOUR: quo_est = prod[36:21];
            ecal_pkg::DSEL_MIN:  quo_est = prod[29:14];
            default:             quo_est = prod[50:35];
        endcase
    end

    assign back = 33'(r_quo) * 33'(dsr);

    always_comb begin
        n_num   = r_num;
        n_sel   = r_sel;
        n_quo   = r_quo;
        n_phase = r_phase;
        if (i_ctl.init) begin
            n_num   = i_ctl.dividend;
            n_sel   = i_ctl.sel;
            n_quo   = '0;
            n_phase = 1'b1;
        end else if (i_ctl.step) begin
            if (r_phase) begin
                n_quo   = quo_est;
                n_phase = 1'b0;
            end else begin
                n_num = r_num - back[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_sel   <= n_sel;
        r_quo   <= n_quo;
        r_phase <= n_phase;
    end

    assign o_stat.more = r_phase;
    assign o_stat.quo  = r_quo;
    assign o_stat.rem  = r_num;

endmodule

// File: rtl/epoch_seconds_to_utc_calendar_unit.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00 UTC into the broken-down UTC
// date and time, one request at a time. A small microprogram drives a shared constant
// divider and a year/month walk. The year walk steps once per whole year passed since
// 1970 and the month walk once per whole month passed in the final year, and each of
// the four divisions (days, weekday, hours, minutes) takes two steps, a reciprocal
// multiply for the quotient and a multiply back for the remainder. A request at or past
// the start of LAST_YEAR ends the year walk early with o_in_range low and all other
// fields zero. The next request is taken as soon as the result has moved into the output
// register, even while that result is stalled.
//
// depends on ecal_pkg and ecal_divider
module epoch_seconds_to_utc_calendar_unit #(
    parameter int unsigned LAST_YEAR = ecal_pkg::LAST_YEAR_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_year_since_1900,
    output logic [3:0]  o_month_index,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour_of_day,
    output logic [5:0]  o_minute_of_hour,
    output logic [5:0]  o_second_of_minute,
    output logic [2:0]  o_weekday,
    output logic [8:0]  o_day_of_year,
    output logic        o_in_range
);

    localparam logic [7:0] LastYy = 8'(LAST_YEAR - ecal_pkg::YEAR_BASE);

    // sequencer
    logic           r_busy, n_busy;
    ecal_pkg::t_pc  r_pc, n_pc;
    ecal_pkg::t_uword uw;

    // datapath
    logic [15:0] r_days, n_days;
    logic [16:0] r_tod,  n_tod;
    logic [7:0]  r_year, n_year;
    logic [3:0]  r_mon,  n_mon;
    logic [8:0]  r_yday, n_yday;
    logic [2:0]  r_wd,   n_wd;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min,  n_min;
    logic [5:0]  r_sec,  n_sec;
    logic        r_oor,  n_oor;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_o_year;
    logic [3:0]  r_o_mon;
    logic [4:0]  r_o_mday;
    logic [4:0]  r_o_hour;
    logic [5:0]  r_o_min;
    logic [5:0]  r_o_sec;
    logic [2:0]  r_o_wd;
    logic [8:0]  r_o_yday;
    logic        r_o_in_range;

    ecal_pkg::t_div_ctl  div_ctl;
    ecal_pkg::t_div_stat div_stat;

    logic       accept;
    logic       out_free;
    logic       emit;
    logic       leap;
    logic [8:0] ylen;
    logic [4:0] mlen;
    logic       year_oor;
    logic       year_more;
    logic       month_more;

    assign uw       = ecal_pkg::ucode(r_pc);
    assign accept   = i_in_valid && !r_busy;
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = r_busy && (uw.op == ecal_pkg::UOP_DONE) && out_free;

    assign leap       = ecal_pkg::leap_yy(r_year);
    assign ylen       = leap ? ecal_pkg::DAYS_LEAP : ecal_pkg::DAYS_YEAR;
    assign mlen       = ecal_pkg::month_len(r_mon, leap);
    assign year_oor   = (r_year >= LastYy);
    assign year_more  = !year_oor && (r_days >= {7'b0, ylen});
    assign month_more = (r_mon < ecal_pkg::LAST_MON) && (r_days >= {11'b0, mlen});

    // the day division is started straight from the request
    always_comb begin
        div_ctl.init  = accept || (r_busy && (uw.op == ecal_pkg::UOP_DIV_INIT));
        div_ctl.step  = r_busy && (uw.op == ecal_pkg::UOP_DIV_STEP);
        div_ctl.dividend = div_stat.rem;
        if (accept) begin
            div_ctl.sel      = ecal_pkg::DSEL_DAY;
            div_ctl.dividend = i_epoch_seconds;
        end else begin
            div_ctl.sel = uw.dsel;
            case (uw.dsel)
                ecal_pkg::DSEL_WEEK: div_ctl.dividend = 32'(r_days) + 32'(r_wd);
                ecal_pkg::DSEL_HOUR: div_ctl.dividend = 32'(r_tod);
                default:             div_ctl.dividend = div_stat.rem;
            endcase
        end
    end

    ecal_divider u_divider (
        .i_clk  (i_clk),
        .i_ctl  (div_ctl),
        .o_stat (div_stat)
    );

    // step counter and jumps
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc + 1'b1;
        unique case (uw.cond)
            ecal_pkg::COND_DIV_MORE:   if (div_stat.more) n_pc = uw.target;
            ecal_pkg::COND_YEAR_MORE:  if (year_more)     n_pc = uw.target;
            ecal_pkg::COND_MONTH_MORE: if (month_more)    n_pc = uw.target;
            default:                   n_pc = r_pc + 1'b1;
        endcase
        if ((uw.op == ecal_pkg::UOP_YEAR) && year_oor) begin
            n_pc = ecal_pkg::PC_DONE;
        end
        if (uw.op == ecal_pkg::UOP_DONE) begin
            n_pc = r_pc;
            if (out_free) begin
                n_busy = 1'b0;
            end
        end
        if (!r_busy) begin
            n_pc = '0;
            if (accept) begin
                n_busy = 1'b1;
            end
        end
    end

    // datapath updates by micro-op
    always_comb begin
        n_days = r_days;
        n_tod  = r_tod;
        n_year = r_year;
        n_mon  = r_mon;
        n_yday = r_yday;
        n_wd   = r_wd;
        n_hour = r_hour;
        n_min  = r_min;
        n_sec  = r_sec;
        n_oor  = r_oor;
        if (r_busy) begin
            case (uw.op)
                ecal_pkg::UOP_SAVE_DAYS: begin
                    n_days = div_stat.quo;
                    n_tod  = div_stat.rem[16:0];
                    n_year = ecal_pkg::FIRST_YY;
                    n_wd   = ecal_pkg::EPOCH_WDAY;
                    n_oor  = 1'b0;
                end
                ecal_pkg::UOP_YEAR: begin
                    if (year_oor) begin
                        n_oor = 1'b1;
                    end else if (year_more) begin
                        n_days = r_days - {7'b0, ylen};
                        n_year = r_year + 1'b1;
                        // 365 and 366 move the weekday by one and two
                        n_wd   = ecal_pkg::wd_add(r_wd, leap ? 2'd2 : 2'd1);
                    end
                end
                ecal_pkg::UOP_MON_START: begin
                    n_yday = r_days[8:0];
                    n_mon  = '0;
                end
                ecal_pkg::UOP_MONTH: begin
                    if (month_more) begin
                        n_days = r_days - {11'b0, mlen};
                        n_mon  = r_mon + 1'b1;
                        n_wd   = ecal_pkg::wd_add(r_wd, 2'(mlen - ecal_pkg::FEB_DAYS));
                    end
                end
                ecal_pkg::UOP_SAVE_WEEK: n_wd = div_stat.rem[2:0];
                ecal_pkg::UOP_SAVE_HOUR: n_hour = div_stat.quo[4:0];
                ecal_pkg::UOP_SAVE_MIN: begin
                    n_min = div_stat.quo[5:0];
                    n_sec = div_stat.rem[5:0];
                end
                default: n_oor = r_oor;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_days <= n_days;
        r_tod  <= n_tod;
        r_year <= n_year;
        r_mon  <= n_mon;
        r_yday <= n_yday;
        r_wd   <= n_wd;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_sec  <= n_sec;
        r_oor  <= n_oor;
    end

    // out of range results carry zeros
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_in_range <= !r_oor;
            r_o_year     <= r_oor ? '0 : r_year;
            r_o_mon      <= r_oor ? '0 : r_mon;
            r_o_mday     <= r_oor ? '0 : (r_days[4:0] + 1'b1);
            r_o_hour     <= r_oor ? '0 : r_hour;
            r_o_min      <= r_oor ? '0 : r_min;
            r_o_sec      <= r_oor ? '0 : r_sec;
            r_o_wd       <= r_oor ? '0 : r_wd;
            r_o_yday     <= r_oor ? '0 : r_yday;
        end
    end

    assign o_in_stall         = r_busy;
    assign o_out_valid        = r_out_valid;
    assign o_year_since_1900  = r_o_year;
    assign o_month_index      = r_o_mon;
    assign o_day_of_month     = r_o_mday;
    assign o_hour_of_day      = r_o_hour;
    assign o_minute_of_hour   = r_o_min;
    assign o_second_of_minute = r_o_sec;
    assign o_weekday          = r_o_wd;
    assign o_day_of_year      = r_o_yday;
    assign o_in_range         = r_o_in_range;

endmodule

// File: rtl/ecal_checker.sv
// port-level checks for the epoch to utc calendar unit, bound to the top level
// depends on ecal_pkg and epoch_seconds_to_utc_calendar_unit
module ecal_checker #(
    parameter int unsigned LAST_YEAR = ecal_pkg::LAST_YEAR_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_year_since_1900,
    input logic [3:0]  o_month_index,
    input logic [4:0]  o_day_of_month,
    input logic [4:0]  o_hour_of_day,
    input logic [5:0]  o_minute_of_hour,
    input logic [5:0]  o_second_of_minute,
    input logic [2:0]  o_weekday,
    input logic [8:0]  o_day_of_year,
    input logic        o_in_range
);

    localparam logic [7:0] LastYy = 8'(LAST_YEAR - ecal_pkg::YEAR_BASE);

    // a stalled result stays valid and its year, day of year, in-range and second fields hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_year_since_1900)
            && $stable(o_day_of_year) && $stable(o_in_range) && $stable(o_second_of_minute)))
        else $error("result changed while stalled");

    // one request in flight: an accepted request blocks the input
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a request");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_range) |-> (o_year_since_1900 == 8'd0 && o_month_index == 4'd0
            && o_day_of_month == 5'd0 && o_hour_of_day == 5'd0 && o_minute_of_hour == 6'd0
            && o_second_of_minute == 6'd0 && o_weekday == 3'd0 && o_day_of_year == 9'd0))
        else $error("out of range result has non-zero fields");

    a_fields_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_in_range) |-> (o_month_index <= 4'd11 && o_day_of_month >= 5'd1
            && o_hour_of_day <= 5'd23 && o_minute_of_hour <= 6'd59
            && o_second_of_minute <= 6'd59 && o_weekday <= 3'd6 && o_day_of_year <= 9'd365
            && o_year_since_1900 >= ecal_pkg::FIRST_YY && o_year_since_1900 < LastYy))
        else $error("calendar field out of its range");

endmodule

bind epoch_seconds_to_utc_calendar_unit ecal_checker #(.LAST_YEAR(LAST_YEAR)) u_ecal_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_year_since_1900  (o_year_since_1900),
    .o_month_index      (o_month_index),
    .o_day_of_month     (o_day_of_month),
    .o_hour_of_day      (o_hour_of_day),
    .o_minute_of_hour   (o_minute_of_hour),
    .o_second_of_minute (o_second_of_minute),
    .o_weekday          (o_weekday),
    .o_day_of_year      (o_day_of_year),
    .o_in_range         (o_in_range)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// testbench for epoch_seconds_to_utc_calendar_unit: second counts in, calendar dates out,
// each date checked against a behavioural breakdown; depends on ecal_pkg and the rtl top
module tb;

    localparam int unsigned LAST_YEAR   = ecal_pkg::LAST_YEAR_DEF;
    localparam int unsigned RANDOM_REQS = 1600;
    localparam int unsigned PHASE_A     = 560;
    localparam int unsigned PHASE_B     = 1120;
    localparam int unsigned HOLD_AT     = 150;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned DRAIN_WAIT  = 250;

    typedef struct packed {
        logic [31:0] secs;
        logic [7:0]  year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
        logic [8:0]  yday;
        logic        in_range;
    } t_utc_date;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [31:0] i_epoch_seconds = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_year_since_1900;
    logic [3:0]  o_month_index;
    logic [4:0]  o_day_of_month;
    logic [4:0]  o_hour_of_day;
    logic [5:0]  o_minute_of_hour;
    logic [5:0]  o_second_of_minute;
    logic [2:0]  o_weekday;
    logic [8:0]  o_day_of_year;
    logic        o_in_range;

    logic [31:0] pending_seconds[$];
    t_utc_date   expected_dates[$];
    int unsigned issued = 0;
    int unsigned accepted = 0;
    int unsigned received = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int          errors = 0;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;

    always #2 i_clk = ~i_clk;

    epoch_seconds_to_utc_calendar_unit #(.LAST_YEAR(LAST_YEAR)) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_year_since_1900  (o_year_since_1900),
        .o_month_index      (o_month_index),
        .o_day_of_month     (o_day_of_month),
        .o_hour_of_day      (o_hour_of_day),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_second_of_minute (o_second_of_minute),
        .o_weekday          (o_weekday),
        .o_day_of_year      (o_day_of_year),
        .o_in_range         (o_in_range)
    );

    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_year(input int unsigned y);
        return is_leap(y) ? 366 : 365;
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        if (m == 1) return is_leap(y) ? 29 : 28;
        if (m == 3 || m == 5 || m == 8 || m == 10) return 30;
        return 31;
    endfunction

    function automatic t_utc_date utc_breakdown(input logic [31:0] secs);
        t_utc_date   r;
        int unsigned days;
        int unsigned tod;
        int unsigned year;
        int unsigned mon;
        int unsigned rem;
        r = '0;
        r.secs = secs;
        days = secs / ecal_pkg::SECS_PER_DAY;
        tod = secs % ecal_pkg::SECS_PER_DAY;
        year = 1970;
        mon = 0;
        while (year < LAST_YEAR && days >= days_in_year(year)) begin
            days -= days_in_year(year);
            year++;
        end
        // past the horizon every field but secs stays zero
        if (year >= LAST_YEAR) return r;
        r.yday = 9'(days);
        rem = days;
        while (mon < 11 && rem >= month_length(mon, year)) begin
            rem -= month_length(mon, year);
            mon++;
        end
        r.year     = 8'(year - ecal_pkg::YEAR_BASE);
        r.month    = 4'(mon);
        r.mday     = 5'(rem + 1);
        r.hour     = 5'(tod / ecal_pkg::SECS_PER_HOUR);
        r.minute   = 6'((tod % ecal_pkg::SECS_PER_HOUR) / ecal_pkg::SECS_PER_MIN);
        r.second   = 6'(tod % ecal_pkg::SECS_PER_MIN);
        r.wday     = 3'((secs / ecal_pkg::SECS_PER_DAY + 4) % ecal_pkg::DAYS_PER_WEEK);
        r.in_range = 1'b1;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] secs,
                               input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s for %0d s: expected %0d, got %0d", $time, name, secs, want, got);
            errors++;
        end
    endtask

    assign tx_idle_pct = (issued < PHASE_A) ? 8 : (issued < PHASE_B) ? 78 : 0;
    assign rx_idle_pct = (received < PHASE_A) ? 78 : (received < PHASE_B) ? 8 : 0;

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_dates.push_back(utc_breakdown(i_epoch_seconds));
                accepted <= accepted + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_seconds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_epoch_seconds <= pending_seconds.pop_front();
                    issued <= issued + 1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long back-pressure once, so the block fills and stalls its requests
    always @(posedge i_clk) begin
        if (!hold_done && received == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : date_monitor
        t_utc_date want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_dates.size() == 0) begin
                    $display("%0t: unexpected date: expected none, got year %0d in_range %0d",
                             $time, o_year_since_1900, o_in_range);
                    errors++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("year", want.secs, want.year, o_year_since_1900);
                    check_field("month", want.secs, want.month, o_month_index);
                    check_field("mday", want.secs, want.mday, o_day_of_month);
                    check_field("hour", want.secs, want.hour, o_hour_of_day);
                    check_field("minute", want.secs, want.minute, o_minute_of_hour);
                    check_field("second", want.secs, want.second, o_second_of_minute);
                    check_field("weekday", want.secs, want.wday, o_weekday);
                    check_field("yday", want.secs, want.yday, o_day_of_year);
                    check_field("in_range", want.secs, want.in_range, o_in_range);
                end
                received <= received + 1;
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial begin : stimulus
        longint unsigned horizon;
        int unsigned     y;
        int unsigned     m;
        int unsigned     d;
        int unsigned     k;
        int unsigned     pick;
        int unsigned     total;
        horizon = 0;
        for (y = 1970; y < LAST_YEAR; y++) horizon += days_in_year(y) * 64'd86400;

        // field extremes, unit boundaries, leap days, century leap year, bit patterns
        pending_seconds = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
                            32'd86399, 32'd86400, 32'd2678399, 32'd2678400, 32'd31535999,
                            32'd31536000, 32'd68169600, 32'd951782400, 32'd951868800,
                            32'd978307199, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
                            32'h5555_5555};
        pending_seconds.push_back(32'(horizon - 1));
        pending_seconds.push_back(32'(horizon));

        for (k = 0; k < RANDOM_REQS; k++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                pending_seconds.push_back($urandom_range(32'(horizon - 1), 0));
            end else if (pick < 85) begin
                // first second of a month, or the last second before it
                y = $urandom_range(LAST_YEAR, 1970);
                m = (y == LAST_YEAR) ? 0 : $urandom_range(11);
                d = 0;
                for (int unsigned i = 1970; i < y; i++) d += days_in_year(i);
                for (int unsigned i = 0; i < m; i++) d += month_length(i, y);
                pending_seconds.push_back(32'(d * 86400) - 32'($urandom_range(1)));
            end else if (pick < 95) begin
                pending_seconds.push_back($urandom_range(32'hFFFF_FFFF, 32'(horizon)));
            end else begin
                pending_seconds.push_back($urandom());
            end
        end
        total = pending_seconds.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (accepted == total);
        wait (expected_dates.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/ecal_pkg.sv
rtl/ecal_divider.sv
rtl/epoch_seconds_to_utc_calendar_unit.sv
rtl/ecal_checker.sv
test/tb.sv
